// ===== rtl/rpn_iterated_map_cycle_length_defines.svh =====
// Assertion macros for the cycle length block.
`ifndef RPN_ITERATED_MAP_CYCLE_LENGTH_DEFINES_SVH
`define RPN_ITERATED_MAP_CYCLE_LENGTH_DEFINES_SVH

// check b in the same cycle as a
`define RIMCL_ASSERT_SAME(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error(msg);

// check b in the cycle after a
`define RIMCL_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error(msg);

`endif

// ===== rtl/rimcl_pkg.sv =====
// Shared types and codes of the cycle length block.
`timescale 1ns / 1ps
package rimcl_pkg;
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_START  = 2'd2;

	localparam logic [2:0] TOK_X   = 3'd0;
	localparam logic [2:0] TOK_N   = 3'd1;
	localparam logic [2:0] TOK_LIT = 3'd2;
	localparam logic [2:0] TOK_ADD = 3'd3;
	localparam logic [2:0] TOK_MUL = 3'd4;
	localparam logic [2:0] TOK_REM = 3'd5;

	localparam logic [1:0] ERR_OK     = 2'd0;
	localparam logic [1:0] ERR_DIVZ   = 2'd1;
	localparam logic [1:0] ERR_MALFORM = 2'd2;

	typedef struct packed {
		logic        done;
		logic [1:0]  err;
		logic [31:0] value;
	} eval_res_t;
endpackage

// ===== rtl/rimcl_moddiv.sv =====
// Iterative remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
module rimcl_moddiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] rem
);
	logic [63:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, dvd_q[63]};
	assign diff  = trial - {1'b0, dvs_q};
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			rem_q <= diff[32] ? trial[31:0] : diff[31:0];
		end
	end
endmodule

// ===== rtl/rimcl_eval.sv =====
// Program store, evaluation stack and token sequencer for one map evaluation.
`timescale 1ns / 1ps
module rimcl_eval #(
	parameter int PROGRAM_DEPTH = 64,
	parameter int STACK_DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     prog_we,
	input  logic [((PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1)-1:0] prog_waddr,
	input  logic [34:0]              prog_wdata,
	input  logic [$clog2(PROGRAM_DEPTH+1)-1:0] prog_len,
	input  logic [31:0]              modulus,
	input  logic                     go,
	input  logic [31:0]              x,
	output rimcl_pkg::eval_res_t     res
);
	import rimcl_pkg::*;

	localparam int AW  = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
	localparam int LW  = $clog2(PROGRAM_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);

	localparam logic [3:0] E_IDLE  = 4'd0;
	localparam logic [3:0] E_FETCH = 4'd1;
	localparam logic [3:0] E_GETB  = 4'd2;
	localparam logic [3:0] E_GETA  = 4'd3;
	localparam logic [3:0] E_OP    = 4'd4;
	localparam logic [3:0] E_MUL   = 4'd5;
	localparam logic [3:0] E_REM   = 4'd6;
	localparam logic [3:0] E_RED   = 4'd7;
	localparam logic [3:0] E_FIN   = 4'd8;
	localparam logic [3:0] E_FINR  = 4'd9;
	localparam logic [3:0] E_FINM  = 4'd10;

	logic [34:0] prog_mem [PROGRAM_DEPTH];
	logic [31:0] stk_mem [STACK_DEPTH];
	logic [34:0] prog_rd_q;
	logic [31:0] stk_rd_q;

	logic [3:0]     state_q;
	logic [AW-1:0]  pc_q;
	logic [SPW-1:0] sp_q;
	logic [2:0]     kind_q;
	logic [31:0]    a_q;
	logic [31:0]    b_q;
	logic [63:0]    prod_q;
	logic [31:0]    x_q;

	logic [2:0]     kind;
	logic [AW-1:0]  prog_raddr;
	logic [SAW-1:0] stk_raddr;
	logic           stk_we;
	logic [SAW-1:0] stk_waddr;
	logic [31:0]    stk_wdata;
	logic           mod_start;
	logic [63:0]    mod_dividend;
	logic [31:0]    mod_divisor;
	logic           mod_done;
	logic [31:0]    mod_rem;
	logic           last_tok;
	logic [32:0]    sum;

	assign kind     = prog_rd_q[34:32];
	assign last_tok = ((LW'(pc_q) + LW'(1)) == prog_len);
	assign sum      = {1'b0, a_q} + {1'b0, b_q};

	rimcl_moddiv u_moddiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (mod_divisor),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_comb begin
		prog_raddr   = (state_q == E_IDLE) ? '0 : AW'(pc_q + AW'(1));
		stk_raddr    = (state_q == E_GETB) ? SAW'(sp_q - SPW'(2)) : SAW'(sp_q - SPW'(1));
		stk_we       = 1'b0;
		stk_waddr    = SAW'(sp_q);
		stk_wdata    = 32'd0;
		mod_start    = 1'b0;
		mod_dividend = 64'd0;
		mod_divisor  = modulus;
		case (state_q)
			E_FETCH: begin
				if (kind <= TOK_LIT && sp_q < SPW'(STACK_DEPTH)) begin
					stk_we = 1'b1;
					case (kind)
						TOK_X:   stk_wdata = x_q;
						TOK_N:   stk_wdata = modulus;
						default: stk_wdata = prog_rd_q[31:0];
					endcase
				end
			end
			E_OP: begin
				if (kind_q == TOK_ADD && modulus != 32'd0) begin
					mod_start    = 1'b1;
					mod_dividend = {31'd0, sum};
				end else if (kind_q == TOK_REM && b_q != 32'd0) begin
					mod_start    = 1'b1;
					mod_dividend = {32'd0, a_q};
					mod_divisor  = b_q;
				end
			end
			E_MUL: begin
				mod_start    = 1'b1;
				mod_dividend = prod_q;
			end
			E_REM: begin
				if (mod_done && modulus != 32'd0) begin
					mod_start    = 1'b1;
					mod_dividend = {32'd0, mod_rem};
				end
			end
			E_RED: begin
				if (mod_done) begin
					stk_we    = 1'b1;
					stk_waddr = SAW'(sp_q - SPW'(2));
					stk_wdata = mod_rem;
				end
			end
			E_FINR: begin
				mod_start    = 1'b1;
				mod_dividend = {32'd0, stk_rd_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (prog_we)
			prog_mem[prog_waddr] <= prog_wdata;
		prog_rd_q <= prog_mem[prog_raddr];
		if (stk_we)
			stk_mem[stk_waddr] <= stk_wdata;
		stk_rd_q <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk) begin
		if (go && state_q == E_IDLE)
			x_q <= x;
		if (state_q == E_FETCH)
			kind_q <= kind;
		if (state_q == E_GETB)
			b_q <= stk_rd_q;
		if (state_q == E_GETA)
			a_q <= stk_rd_q;
		if (state_q == E_OP)
			prod_q <= a_q * b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			pc_q    <= '0;
			sp_q    <= '0;
			res     <= '0;
		end else begin
			res.done <= 1'b0;
			case (state_q)
				E_IDLE: begin
					if (go) begin
						sp_q <= '0;
						pc_q <= '0;
						if (prog_len == '0) begin
							res     <= '{done: 1'b1, err: ERR_MALFORM, value: 32'd0};
						end else begin
							state_q <= E_FETCH;
						end
					end
				end
				E_FETCH: begin
					if (kind <= TOK_LIT) begin
						if (sp_q >= SPW'(STACK_DEPTH)) begin
							res     <= '{done: 1'b1, err: ERR_MALFORM, value: 32'd0};
							state_q <= E_IDLE;
						end else begin
							sp_q <= sp_q + SPW'(1);
							if (last_tok) begin
								state_q <= E_FIN;
							end else begin
								pc_q    <= AW'(pc_q + AW'(1));
								state_q <= E_FETCH;
							end
						end
					end else if (kind <= TOK_REM) begin
						if (sp_q < SPW'(2)) begin
							res     <= '{done: 1'b1, err: ERR_MALFORM, value: 32'd0};
							state_q <= E_IDLE;
						end else begin
							state_q <= E_GETB;
						end
					end else begin
						res     <= '{done: 1'b1, err: ERR_MALFORM, value: 32'd0};
						state_q <= E_IDLE;
					end
				end
				E_GETB: state_q <= E_GETA;
				E_GETA: state_q <= E_OP;
				E_OP: begin
					if (kind_q == TOK_REM) begin
						if (b_q == 32'd0) begin
							res     <= '{done: 1'b1, err: ERR_DIVZ, value: 32'd0};
							state_q <= E_IDLE;
						end else begin
							state_q <= E_REM;
						end
					end else if (modulus == 32'd0) begin
						res     <= '{done: 1'b1, err: ERR_DIVZ, value: 32'd0};
						state_q <= E_IDLE;
					end else if (kind_q == TOK_MUL) begin
						state_q <= E_MUL;
					end else begin
						state_q <= E_RED;
					end
				end
				E_MUL: state_q <= E_RED;
				E_REM: begin
					if (mod_done) begin
						if (modulus == 32'd0) begin
							res     <= '{done: 1'b1, err: ERR_DIVZ, value: 32'd0};
							state_q <= E_IDLE;
						end else begin
							state_q <= E_RED;
						end
					end
				end
				E_RED: begin
					if (mod_done) begin
						sp_q <= sp_q - SPW'(1);
						if (last_tok) begin
							state_q <= E_FIN;
						end else begin
							pc_q    <= AW'(pc_q + AW'(1));
							state_q <= E_FETCH;
						end
					end
				end
				E_FIN: begin
					if (sp_q == '0) begin
						res     <= '{done: 1'b1, err: ERR_MALFORM, value: 32'd0};
						state_q <= E_IDLE;
					end else if (modulus == 32'd0) begin
						res     <= '{done: 1'b1, err: ERR_DIVZ, value: 32'd0};
						state_q <= E_IDLE;
					end else begin
						state_q <= E_FINR;
					end
				end
				E_FINR: state_q <= E_FINM;
				E_FINM: begin
					if (mod_done) begin
						res     <= '{done: 1'b1, err: ERR_OK, value: mod_rem};
						state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/rpn_iterated_map_cycle_length.sv =====
// Top level: command port, modulus register and tortoise-and-hare sequencer.
//
// Usage:
//   Commands enter on start/action/token_kind/literal_value/seed; one is
//   taken at a clock edge with start high and busy low. Clear and append
//   complete in that cycle and give no result. A start command runs the
//   cycle search on the stored program and raises busy until it ends.
//   The result appears on cycle_length/error_code with done high for one
//   cycle, in the cycle that busy falls; a new command may be taken then.
//   Each map evaluation pushes one stack entry per push token and runs
//   the 64-step remainder unit once per add or multiply token, twice per
//   remainder token and once more for the final reduction. A search
//   needs roughly three evaluations per tortoise step plus one per step
//   of the cycle count.
//   The modulus is written through modulus_valid/modulus_ready; ready is
//   low while busy. Reset empties the program, sets the modulus to 1 and
//   returns to idle. The receiver cannot stall: done is a single strobe.
`timescale 1ns / 1ps
module rpn_iterated_map_cycle_length #(
	parameter int PROGRAM_DEPTH = 64,
	parameter int STACK_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [2:0]  token_kind,
	input  logic [31:0] literal_value,
	input  logic [31:0] seed,
	output logic        done,
	output logic [31:0] cycle_length,
	output logic [1:0]  error_code,
	input  logic        modulus_valid,
	output logic        modulus_ready,
	input  logic [31:0] modulus
);
	import rimcl_pkg::*;

	localparam int AW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
	localparam int LW = $clog2(PROGRAM_DEPTH + 1);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_T    = 3'd1;
	localparam logic [2:0] F_H1   = 3'd2;
	localparam logic [2:0] F_H2   = 3'd3;
	localparam logic [2:0] F_CNT  = 3'd4;

	logic [2:0]    state_q;
	logic [31:0]   modulus_q;
	logic [LW-1:0] len_q;
	logic [31:0]   t_q;
	logic [31:0]   h_q;
	logic [31:0]   cnt_q;
	logic [31:0]   x_q;
	logic          go_q;
	logic          first_q;
	logic          prog_we;
	eval_res_t     res;

	assign busy          = (state_q != F_IDLE);
	assign modulus_ready = !busy;
	assign prog_we       = start && !busy && action == ACT_APPEND
		&& len_q < LW'(PROGRAM_DEPTH);

	rimcl_eval #(
		.PROGRAM_DEPTH (PROGRAM_DEPTH),
		.STACK_DEPTH   (STACK_DEPTH)
	) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.prog_we    (prog_we),
		.prog_waddr (AW'(len_q)),
		.prog_wdata ({token_kind, literal_value}),
		.prog_len   (len_q),
		.modulus    (modulus_q),
		.go         (go_q),
		.x          (x_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			modulus_q    <= 32'd1;
			len_q        <= '0;
			go_q         <= 1'b0;
			done         <= 1'b0;
			first_q      <= 1'b0;
			cycle_length <= '0;
			error_code   <= ERR_OK;
		end else begin
			done <= 1'b0;
			go_q <= 1'b0;
			if (modulus_valid && modulus_ready)
				modulus_q <= modulus;
			case (state_q)
				F_IDLE: begin
					if (start) begin
						case (action)
							ACT_CLEAR:  len_q <= '0;
							ACT_APPEND: begin
								if (prog_we)
									len_q <= len_q + LW'(1);
							end
							ACT_START: begin
								x_q     <= seed;
								go_q    <= 1'b1;
								first_q <= 1'b1;
								state_q <= F_T;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					if (res.done) begin
						if (res.err != ERR_OK) begin
							done         <= 1'b1;
							error_code   <= res.err;
							cycle_length <= 32'd0;
							state_q      <= F_IDLE;
						end else begin
							go_q <= 1'b1;
							case (state_q)
								F_T: begin
									t_q     <= res.value;
									x_q     <= first_q ? res.value : h_q;
									state_q <= F_H1;
								end
								F_H1: begin
									h_q     <= res.value;
									x_q     <= res.value;
									state_q <= F_H2;
								end
								F_H2: begin
									h_q     <= res.value;
									first_q <= 1'b0;
									x_q     <= t_q;
									if (res.value == t_q) begin
										cnt_q   <= 32'd1;
										state_q <= F_CNT;
									end else begin
										state_q <= F_T;
									end
								end
								F_CNT: begin
									h_q <= res.value;
									x_q <= res.value;
									if (res.value == t_q) begin
										go_q         <= 1'b0;
										done         <= 1'b1;
										error_code   <= ERR_OK;
										cycle_length <= cnt_q;
										state_q      <= F_IDLE;
									end else begin
										cnt_q <= cnt_q + 32'd1;
									end
								end
								default: state_q <= F_IDLE;
							endcase
						end
					end
				end
			endcase
		end
	end
endmodule

// ===== rtl/rimcl_checker.sv =====
// Port-level checks of the cycle length block and their binding.
`timescale 1ns / 1ps
`include "rpn_iterated_map_cycle_length_defines.svh"
module rimcl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  action,
	input logic        done,
	input logic [31:0] cycle_length,
	input logic [1:0]  error_code,
	input logic        modulus_ready
);
	import rimcl_pkg::*;

	`RIMCL_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy && action == ACT_START, busy, "start transfer did not raise busy")
	`RIMCL_ASSERT_SAME(a_done_end, clk, arst_n, done, $past(busy) && !busy, "result without a running search")
	`RIMCL_ASSERT_SAME(a_err_len, clk, arst_n, done && error_code != ERR_OK, cycle_length == 32'd0, "error result with nonzero length")
	`RIMCL_ASSERT_SAME(a_cfg_idle, clk, arst_n, busy, !modulus_ready, "modulus write open while busy")
endmodule

bind rpn_iterated_map_cycle_length rimcl_checker u_rimcl_checker (.*);
